// ----- rtl/ilid_pkg.sv -----
// Shared types and constants for the indexed list with insert and delete.
package ilid_pkg;

    localparam int CAPACITY_DEF = 16;
    // Widest index/count the cells ever see (capacity up to 256, count up to 256).
    localparam int IDX_MAX_W = 9;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_WRITE  = 3'd3,
        MODE_READ   = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [4:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_word;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_t;

    // Broadcast to every cell in the row
    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   pos;
        logic [IDX_MAX_W-1:0]   count;
        logic signed [31:0]     value;
    } cell_ctl_t;

endpackage

// ----- rtl/indexed_list_insert_delete.sv -----
// Top level of the bounded ordered list: control, occupancy and the row of cells.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------
//  request   | in        | start high, busy low at edge   | mode, position, value
//  response  | out       | done high for one cycle        | read_word, entry_count,
//            |           |                                | is_empty, status
//
// On each item the cells that move shift toward their neighbour at the
// same edge, and the result is shown on the next cycle with done.
// busy never rises, so a new item may follow in every cycle.
// Reset (rst_n low, asynchronous) clears the count and done; stored words
// are left as they are and only ever read below the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ilid_pkg::req_t  request,
    output logic            done,
    output ilid_pkg::rsp_t  response
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int W     = ilid_pkg::IDX_MAX_W;
    localparam logic [W-1:0] CAP_W = W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    ilid_pkg::rsp_t      rsp_reg;
    ilid_pkg::rsp_t      rsp_next;

    ilid_pkg::cell_ctl_t ctl;
    ilid_pkg::status_t   status_c;
    logic                accept;
    logic                read_hit;
    logic [W-1:0]        pos_w;
    logic [W-1:0]        cnt_w;
    logic signed [31:0]  read_or;

    logic signed [31:0]  cell_word [CAPACITY];
    logic                cell_at   [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pos_w  = W'(request.position);
    assign cnt_w  = W'(count_reg);

    // Operation decode: checks, broadcast to the row, next count
    always_comb
    begin
        ctl.op    = ilid_pkg::CELL_HOLD;
        ctl.pos   = pos_w;
        ctl.count = cnt_w;
        ctl.value = request.value;
        status_c  = ilid_pkg::ST_OK;
        count_next = count_reg;
        read_hit  = 1'b0;
        unique case (request.mode)
            ilid_pkg::MODE_APPEND:
            begin
                if (cnt_w >= CAP_W)
                begin
                    status_c = ilid_pkg::ST_FULL;
                end
                else
                begin
                    // insert at the end
                    ctl.op     = ilid_pkg::CELL_INSERT;
                    ctl.pos    = cnt_w;
                    count_next = count_reg + 1'b1;
                end
            end
            ilid_pkg::MODE_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status_c = ilid_pkg::ST_BAD_INDEX;
                end
                else if (cnt_w >= CAP_W)
                begin
                    status_c = ilid_pkg::ST_FULL;
                end
                else
                begin
                    ctl.op     = ilid_pkg::CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ilid_pkg::MODE_DELETE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_c = ilid_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    ctl.op     = ilid_pkg::CELL_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            ilid_pkg::MODE_WRITE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_c = ilid_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    ctl.op = ilid_pkg::CELL_WRITE;
                end
            end
            ilid_pkg::MODE_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_c = ilid_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    read_hit = 1'b1;
                end
            end
            ilid_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused modes change nothing
                status_c = ilid_pkg::ST_OK;
            end
        endcase
        if (!accept)
        begin
            ctl.op     = ilid_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // The row of cells; each hands its word to both neighbours
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] lower_w;
        logic signed [31:0] upper_w;
        if (g == 0)
        begin : g_first
            assign lower_w = request.value;
        end
        else
        begin : g_mid_lo
            assign lower_w = cell_word[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = cell_word[g+1];
        end
        ilid_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .from_lower (lower_w),
            .from_upper (upper_w),
            .word       (cell_word[g]),
            .at_pos     (cell_at[g])
        );
    end

    // Read tap: at most one cell matches the position
    always_comb
    begin
        read_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_at[i])
            begin
                read_or = read_or | cell_word[i];
            end
        end
    end

    always_comb
    begin
        rsp_next.read_word   = read_hit ? read_or : 32'sd0;
        rsp_next.entry_count = 5'(count_next);
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.status      = status_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

// ----- rtl/ilid_cell.sv -----
// One storage cell of the list row: holds a word, takes from a neighbour on shifts.
module ilid_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  ilid_pkg::cell_ctl_t               ctl,
    input  logic signed [31:0]                from_lower,
    input  logic signed [31:0]                from_upper,
    output logic signed [31:0]                word,
    output logic                              at_pos
);

    localparam logic [ilid_pkg::IDX_MAX_W-1:0] MY_IDX  = ilid_pkg::IDX_MAX_W'(IDX);
    localparam logic [ilid_pkg::IDX_MAX_W-1:0] NXT_IDX = ilid_pkg::IDX_MAX_W'(IDX + 1);

    logic signed [31:0] word_reg;
    logic signed [31:0] word_next;

    assign at_pos = (ctl.pos == MY_IDX);
    assign word   = word_reg;

    always_comb
    begin
        word_next = word_reg;
        unique case (ctl.op)
            ilid_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            ilid_pkg::CELL_WRITE:
            begin
                if (at_pos)
                begin
                    word_next = ctl.value;
                end
            end
            ilid_pkg::CELL_INSERT:
            begin
                // entries from pos up to count-1 move up one place
                if (at_pos)
                begin
                    word_next = ctl.value;
                end
                else if ((MY_IDX > ctl.pos) && (MY_IDX <= ctl.count))
                begin
                    word_next = from_lower;
                end
            end
            ilid_pkg::CELL_DELETE:
            begin
                if ((MY_IDX >= ctl.pos) && (NXT_IDX < ctl.count))
                begin
                    word_next = from_upper;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ----- rtl/ilid_checker.sv -----
// Port-level checks for the indexed list, bound to the top level.
module ilid_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  ilid_pkg::req_t  request,
    input  logic            done,
    input  ilid_pkg::rsp_t  response
);

    // every accepted item gives its result on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result missing after accepted item");

    // no result without an item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without accepted item");

    // empty flag agrees with count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.is_empty == (response.entry_count == 5'd0)))
        else $error("empty flag disagrees with count");

    // clear leaves an empty list with ok status
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.mode == ilid_pkg::MODE_CLEAR) |=>
        (response.entry_count == 5'd0 && response.status == ilid_pkg::ST_OK))
        else $error("clear did not empty the list");

    // a failed item leaves the count unchanged and reads zero
    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && response.status != ilid_pkg::ST_OK) |->
        (response.entry_count == $past(response.entry_count) &&
         response.read_word == 32'sd0))
        else $error("failed item changed state");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the indexed list with insert, delete, overwrite, read and clear.
`timescale 1ns / 1ps

module testbench;
    import ilid_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int PLAN_ROWS    = 21;
    localparam int SETTLE       = 5;      // block answers on the cycle after the item
    localparam int MAX_REPORTS  = 10;

    // Mode codes the block decodes as no-ops
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // One row of the directed plan. rep > 1 repeats the row with value + n.
    // pinned rows carry a hand-written answer; the rest are predicted.
    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  pos;
        logic [31:0] value;
        logic [4:0]  rep;
        logic        pinned;
        rsp_t        want;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // empty list: every indexed access is out of range
        '{MODE_READ,     5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_BAD_INDEX}},
        '{MODE_DELETE,   5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_BAD_INDEX}},
        '{MODE_INSERT,   5'd1,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_BAD_INDEX}},
        // extremes of the word, insert at the head and at the tail
        '{MODE_APPEND,   5'd0,  WORD_MAX,      5'd1,  1'b1, '{32'h0, 5'd1, 1'b0, ST_OK}},
        '{MODE_INSERT,   5'd0,  WORD_MIN,      5'd1,  1'b1, '{32'h0, 5'd2, 1'b0, ST_OK}},
        '{MODE_INSERT,   5'd2,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd3, 1'b0, ST_OK}},
        '{MODE_READ,     5'd0,  32'h0,         5'd1,  1'b1, '{WORD_MIN, 5'd3, 1'b0, ST_OK}},
        '{MODE_WRITE,    5'd1,  32'h5A5A_A5A5, 5'd1,  1'b0, '0},
        '{MODE_SPARE_LO, 5'd31, 32'hFFFF_FFFF, 5'd1,  1'b0, '0},
        '{MODE_SPARE_HI, 5'd0,  32'h1234_5678, 5'd1,  1'b0, '0},
        '{MODE_DELETE,   5'd1,  32'h0,         5'd1,  1'b0, '0},
        // fill up to one short of capacity, then insert at the count
        '{MODE_APPEND,   5'd0,  32'h1000_0000, 5'd13, 1'b0, '0},
        '{MODE_INSERT,   5'd15, 32'hC0DE_0015, 5'd1,  1'b0, '0},
        // full list: full status, but a bad index wins over full
        '{MODE_APPEND,   5'd0,  32'h0BAD_0000, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_FULL}},
        '{MODE_INSERT,   5'd16, 32'h0BAD_0001, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_FULL}},
        '{MODE_INSERT,   5'd31, 32'h0BAD_0002, 5'd1,  1'b1, '{32'h0, 5'd16, 1'b0, ST_BAD_INDEX}},
        '{MODE_READ,     5'd15, 32'h0,         5'd1,  1'b0, '0},
        '{MODE_DELETE,   5'd15, 32'h0,         5'd1,  1'b0, '0},
        '{MODE_WRITE,    5'd31, 32'hFFFF_0000, 5'd1,  1'b1, '{32'h0, 5'd15, 1'b0, ST_BAD_INDEX}},
        // clear leaves the words but hides them
        '{MODE_CLEAR,    5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
        '{MODE_READ,     5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0, 1'b1, ST_BAD_INDEX}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t response;

    always #5 clk = ~clk;

    indexed_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    // Shadow copy of the list, advanced once per accepted item
    logic signed [31:0] shadow_words [CAPACITY];
    int                 shadow_fill = 0;

    rsp_t pending_answers [$];

    int mismatches   = 0;
    int answers_seen = 0;
    int items_sent   = 0;
    int ok_seen      = 0;
    int bad_seen     = 0;
    int full_seen    = 0;
    int deepest_fill = 0;

    // Apply one item to the shadow list and return the answer it should give
    function automatic rsp_t list_step(input req_t item);
        rsp_t ans;
        int   at;
        int   i;
        ans    = '0;
        at     = int'(item.position);
        ans.status = ST_OK;
        case (item.mode)
            MODE_APPEND:
                if (shadow_fill >= CAPACITY)
                    ans.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_fill] = item.value;
                    shadow_fill++;
                end
            MODE_INSERT:
                if (at > shadow_fill)
                    ans.status = ST_BAD_INDEX;
                else if (shadow_fill >= CAPACITY)
                    ans.status = ST_FULL;
                else
                begin
                    for (i = shadow_fill; i > at; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[at] = item.value;
                    shadow_fill++;
                end
            MODE_DELETE:
                if (at >= shadow_fill)
                    ans.status = ST_BAD_INDEX;
                else
                begin
                    for (i = at; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_fill--;
                end
            MODE_WRITE:
                if (at >= shadow_fill)
                    ans.status = ST_BAD_INDEX;
                else
                    shadow_words[at] = item.value;
            MODE_READ:
                if (at >= shadow_fill)
                    ans.status = ST_BAD_INDEX;
                else
                    ans.read_word = shadow_words[at];
            MODE_CLEAR:
                shadow_fill = 0;
            default: ;
        endcase
        ans.entry_count = shadow_fill[4:0];
        ans.is_empty    = (shadow_fill == 0);
        if (shadow_fill > deepest_fill)
            deepest_fill = shadow_fill;
        return ans;
    endfunction

    // Present an item and hold it until the block takes it; busy is read
    // just after the edge, so it is the value the block saw at that edge.
    task automatic issue(input req_t item, input logic pinned, input rsp_t pinned_ans);
        rsp_t predicted;
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        predicted = list_step(item);
        pending_answers.push_back(pinned ? pinned_ans : predicted);
        items_sent++;
    endtask

    // Drop start for a few cycles, optionally until every answer is back
    task automatic hold_off(input int cycles, input logic drain);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
        if (drain)
            while (pending_answers.size() != 0)
                @(posedge clk);
    endtask

    // Answer checker: one answer per done cycle, against the oldest item
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] answer with no item outstanding: word %h count %0d",
                             $realtime, response.read_word, response.entry_count);
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_seen++;
                case (want.status)
                    ST_OK:        ok_seen++;
                    ST_BAD_INDEX: bad_seen++;
                    default:      full_seen++;
                endcase
                if (response.read_word !== want.read_word
                    || response.entry_count !== want.entry_count
                    || response.is_empty !== want.is_empty
                    || response.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("[%0t] answer %0d: word %h/%h count %0d/%0d ",
                               $realtime, answers_seen,
                               response.read_word, want.read_word,
                               response.entry_count, want.entry_count);
                        $display("empty %b/%b status %0d/%0d (got/expected)",
                                 response.is_empty, want.is_empty,
                                 response.status, want.status);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        req_t      item;
        plan_row_t row;
        int        r;
        int        k;
        int        n;
        int        burst_left;
        int        roll;
        logic      grow;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan
        for (r = 0; r < PLAN_ROWS; r++)
        begin
            row = PLAN[r];
            for (k = 0; k < int'(row.rep); k++)
            begin
                item.mode     = row.mode;
                item.position = row.pos;
                item.value    = row.value + k;
                issue(item, row.pinned, row.want);
            end
        end
        // let the list settle completely before the random part
        hold_off(3, 1'b1);

        // Random part: phases that lean towards growing or shrinking the
        // list so the count sweeps between empty and full, mostly valid
        // indexes with some out-of-range ones mixed in.
        burst_left = 0;
        grow       = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 96 == 0)
                grow = 1'($urandom_range(0, 1));
            if (n != 0 && n % 400 == 0)
            begin
                hold_off($urandom_range(0, 3), 1'b1);
                burst_left = $urandom_range(1, 24);
            end
            else if (burst_left == 0)
            begin
                // roughly one burst in four runs straight into the next
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 6), 1'b0);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            roll = $urandom_range(0, 99);
            if (grow)
                item.mode = (roll < 35) ? MODE_APPEND :
                            (roll < 65) ? MODE_INSERT :
                            (roll < 75) ? MODE_DELETE :
                            (roll < 85) ? MODE_WRITE  :
                            (roll < 96) ? MODE_READ   :
                            (roll < 97) ? MODE_CLEAR  :
                            (roll < 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else
                item.mode = (roll < 10) ? MODE_APPEND :
                            (roll < 20) ? MODE_INSERT :
                            (roll < 55) ? MODE_DELETE :
                            (roll < 69) ? MODE_WRITE  :
                            (roll < 93) ? MODE_READ   :
                            (roll < 95) ? MODE_CLEAR  :
                            (roll < 97) ? MODE_SPARE_LO : MODE_SPARE_HI;

            if ($urandom_range(0, 9) == 0 || shadow_fill == 0)
                item.position = 5'($urandom_range(0, 31));
            else if (item.mode == MODE_INSERT)
                item.position = 5'($urandom_range(0, shadow_fill));
            else
                item.position = 5'($urandom_range(0, shadow_fill - 1));

            case ($urandom_range(0, 7))
                0:       item.value = WORD_MAX;
                1:       item.value = WORD_MIN;
                2:       item.value = 32'h0;
                3:       item.value = 32'hFFFF_FFFF;
                default: item.value = $urandom;
            endcase

            issue(item, 1'b0, '0);
        end

        hold_off(0, 1'b1);
        repeat (SETTLE)
            @(posedge clk);

        $display("Sent %0d items, checked %0d answers: %0d ok, %0d out of range, %0d full.",
                 items_sent, answers_seen, ok_seen, bad_seen, full_seen);
        $display("List reached %0d of %0d entries; %0d mismatches.",
                 deepest_fill, CAPACITY, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this
    initial
    begin
        #1_000_000;
        $display("Timed out with %0d answers still outstanding.", pending_answers.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- indexed_list_insert_delete.f -----
rtl/ilid_pkg.sv
rtl/ilid_cell.sv
rtl/indexed_list_insert_delete.sv
rtl/ilid_checker.sv
test/testbench.sv
